FILE: sv/crn_pkg.sv
package crn_pkg;

    localparam int unsigned ONE_Q16 = 65536;

    typedef enum logic [1:0] {
        MODE_FB      = 2'd0,
        MODE_MIN     = 2'd1,
        MODE_PENALTY = 2'd2,
        MODE_RSVD    = 2'd3
    } mode_t;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_SIGMA = 2'd2;

    // one classified element, as passed from the front to the back end
    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] v;
        logic signed [32:0] d;      // v - vbar
        logic               last;
    } elem_t;

    // 32 x 32 unsigned multiply helper
    function automatic logic [63:0] umul32(input logic [31:0] a, input logic [31:0] b);
        umul32 = {32'd0, a} * {32'd0, b};
    endfunction

endpackage

FILE: sv/crn_sqrt.sv
module crn_sqrt
    import crn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic        done,
    output logic [31:0] root
);

    // two result bits a cycle
    logic [63:0] op_reg, op_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] op_a, res_a, bit_a;

    always_comb begin
        op_a  = op_reg;
        res_a = res_reg;
        bit_a = bit_reg;
        if (op_a >= res_a + bit_a) begin
            op_a  = op_a - (res_a + bit_a);
            res_a = (res_a >> 1) + bit_a;
        end else begin
            res_a = res_a >> 1;
        end
        bit_a = bit_a >> 2;
        op_next  = op_a;
        res_next = res_a;
        bit_next = bit_a;
        if (bit_a != 64'd0) begin
            if (op_a >= res_a + bit_a) begin
                op_next  = op_a - (res_a + bit_a);
                res_next = (res_a >> 1) + bit_a;
            end else begin
                res_next = res_a >> 1;
            end
            bit_next = bit_a >> 2;
        end
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            op_next   = radicand;
            res_next  = 64'd0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end else if (busy_reg && bit_next == 64'd0) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

FILE: sv/crn_front.sv
module crn_front
    import crn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] y,
    input  logic [31:0] v,
    input  logic [31:0] vr,
    input  logic        last,
    output logic        q_valid,
    input  logic        q_ready,
    output elem_t       q_data
);

    // two-entry queue
    elem_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg].y    <= y;
            mem_reg[wp_reg].v    <= v;
            mem_reg[wp_reg].d    <= {v[31], v} - {vr[31], vr};
            mem_reg[wp_reg].last <= last;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue overfull");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !in_ready) else $error("ready while full");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !q_valid) else $error("valid while empty");

endmodule

FILE: sv/crn_back.sv
module crn_back
    import crn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mode_t       mode,
    input  logic [16:0] alpha,
    input  logic [30:0] sigma,
    input  logic        q_valid,
    output logic        q_ready,
    input  elem_t       q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_residual,
    output logic [31:0] out_norm,
    output logic        out_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_SIGMA, S_A, S_SQ, S_ROOT, S_RWAIT, S_PROD, S_T1, S_T2,
        S_RSQ, S_ACC, S_NORM, S_NWAIT, S_OUT
    } state_t;

    state_t state_reg;
    elem_t  e_reg;
    logic signed [31:0] a_reg, r_reg;
    // a + v - root reaches below -2^32
    logic signed [33:0] base_reg;
    logic [63:0] p_reg, q_reg, sum_reg;
    logic signed [63:0] t1_reg;
    logic [31:0] norm_reg;
    logic        sq_start;
    logic [63:0] sq_in;
    logic        sq_busy, sq_done;
    logic [31:0] sq_root;

    logic [16:0] w;
    logic [31:0] dm, am, bm, pp, qq, prodc, mag;
    logic signed [63:0] sd, fl, asum, t1, rsum;
    logic signed [51:0] t1w;
    logic [64:0] acc;
    logic [63:0] t2;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) sat32 = 32'sh7fffffff;
        else if (x < -64'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = x[31:0];
    endfunction

    function automatic logic [31:0] absv(input logic signed [31:0] x);
        absv = x[31] ? 32'(-{1'b1, x}) : x;
    endfunction

    assign w     = (alpha > 17'(ONE_Q16)) ? 17'(ONE_Q16) : alpha;
    assign dm    = e_reg.d[32] ? 32'(-e_reg.d) : e_reg.d[31:0];
    assign sd    = e_reg.d[32] ? -$signed(p_reg) : $signed(p_reg);
    assign fl    = sd >>> 16;
    assign asum  = 64'(e_reg.y) + fl;
    assign am    = absv(a_reg);
    assign bm    = absv(e_reg.v);
    assign pp    = (a_reg > 0 && mode == MODE_FB) || (mode != MODE_FB && e_reg.y > 0)
                   ? (mode == MODE_FB ? a_reg : e_reg.y) : 32'd0;
    assign qq    = e_reg.v > 0 ? e_reg.v : 32'd0;
    assign prodc = (p_reg[63:16] > 48'h7fffffff) ? 32'h7fffffff : p_reg[47:16];
    assign t1w   = $signed({1'b0, w}) * base_reg;
    assign t1    = 64'(t1w >>> 16);
    assign t2    = umul32(32'(17'(ONE_Q16) - w), q_reg[31:0]) >> 16;
    assign rsum  = t1_reg + $signed(t2);
    assign mag   = absv(r_reg);
    assign acc   = {1'b0, sum_reg} + {1'b0, p_reg};
    assign sq_start = (state_reg == S_SQ) || (state_reg == S_NORM);
    assign sq_in    = (state_reg == S_NORM) ? sum_reg : p_reg + q_reg;
    assign q_ready  = (state_reg == S_IDLE);

    crn_sqrt u_sqrt (
        .aclk, .aresetn, .start(sq_start), .radicand(sq_in),
        .busy(sq_busy), .done(sq_done), .root(sq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            sum_reg   <= 64'd0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (q_valid) begin
                    e_reg <= q_data;
                    state_reg <= S_SIGMA;
                end
                S_SIGMA: begin
                    p_reg <= umul32({1'b0, sigma}, dm);
                    if (mode == MODE_FB) begin
                        state_reg <= S_A;
                    end else begin
                        base_reg <= 34'((e_reg.y < e_reg.v) ? e_reg.y : e_reg.v);
                        state_reg <= (mode == MODE_PENALTY) ? S_PROD : S_RSQ;
                        r_reg <= (e_reg.y < e_reg.v) ? e_reg.y : e_reg.v;
                    end
                end
                S_A: begin
                    a_reg <= sat32(asum);
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    p_reg <= umul32(am, am);
                    q_reg <= umul32(bm, bm);
                    state_reg <= S_SQ;
                end
                S_SQ: state_reg <= S_RWAIT;
                S_RWAIT: if (sq_done) begin
                    base_reg <= 34'(64'(a_reg) + 64'(e_reg.v) - 64'({32'd0, sq_root}));
                    state_reg <= S_PROD;
                end
                S_PROD: begin
                    p_reg <= umul32(pp, qq);
                    state_reg <= S_T1;
                end
                S_T1: begin
                    q_reg <= {32'd0, prodc};
                    t1_reg <= t1;
                    state_reg <= S_T2;
                end
                S_T2: begin
                    r_reg <= sat32(rsum);
                    state_reg <= S_RSQ;
                end
                S_RSQ: begin
                    p_reg <= umul32(mag, mag);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    sum_reg <= acc[64] ? 64'hffff_ffff_ffff_ffff : acc[63:0];
                    state_reg <= e_reg.last ? S_NORM : S_OUT;
                    norm_reg <= 32'd0;
                end
                S_NORM: state_reg <= S_NWAIT;
                S_NWAIT: if (sq_done) begin
                    norm_reg <= sq_root;
                    sum_reg <= 64'd0;
                    state_reg <= S_OUT;
                end
                S_OUT: if (!out_valid || out_ready) begin
                    out_residual <= r_reg;
                    out_norm <= norm_reg;
                    out_last <= e_reg.last;
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (out_valid && out_ready && state_reg != S_OUT) out_valid <= 1'b0;
        end
    end

    a_nv: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_last |-> out_norm == 32'd0) else $error("norm without last");
    a_sq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RWAIT |-> sq_busy || sq_done) else $error("root lost");
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NWAIT && sq_done |=> sum_reg == 64'd0) else $error("sum not cleared");

endmodule

FILE: sv/complementarity_residual_norm_top.sv
// channel | ports                | tdata / tuser
// input   | s_axis_t*            | tdata: y, v, vbar; tlast: last_element
// result  | m_axis_t*            | tdata: residual, norm; tuser: norm_valid
// config  | cfg_we/idx/data      | 0 mode, 1 alpha, 2 sigma
// Each element holds the back end longest in Fischer-Burmeister mode, less in
// penalized mode and least in natural min mode, and the last element holds it
// further for the norm; the shared 2-bit-a-cycle square root unit sets the long cases.
// A result waiting on the output register holds the back end until it leaves.
// Reset is synchronous and active low; it clears the accumulator.
// A two-entry queue lets the input side run ahead of the back end.
module complementarity_residual_norm_top
    import crn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // y, v, vbar
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // residual_value, vector_norm
    output logic        m_axis_tuser,   // norm_valid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [30:0] cfg_data
);

    mode_t       mode_reg;
    logic [16:0] alpha_reg;
    logic [30:0] sigma_reg;
    logic        q_valid, q_ready;
    elem_t       q_data;
    logic [31:0] res, nrm;

    // hold the configuration registers; the user must write them only while idle (not enforced here)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_FB;
            alpha_reg <= 17'(ONE_Q16);
            sigma_reg <= 31'd0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_MODE:  mode_reg  <= mode_t'(cfg_data[1:0]);
                REG_ALPHA: alpha_reg <= cfg_data[16:0];
                REG_SIGMA: sigma_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    crn_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .y(s_axis_tdata[31:0]), .v(s_axis_tdata[63:32]), .vr(s_axis_tdata[95:64]),
        .last(s_axis_tlast),
        .q_valid, .q_ready, .q_data
    );

    // treat mode 3 as natural min
    crn_back u_back (
        .aclk, .aresetn,
        .mode(mode_reg == MODE_RSVD ? MODE_MIN : mode_reg),
        .alpha(alpha_reg), .sigma(sigma_reg),
        .q_valid, .q_ready, .q_data,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_residual(res), .out_norm(nrm), .out_last(m_axis_tuser)
    );

    assign m_axis_tdata = {nrm, res};

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import crn_pkg::*;

    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_WAIT = 120;

    typedef struct packed {
        logic signed [31:0] residual;
        logic [31:0]        norm;
        logic               norm_valid;
    } residual_t;

    // Residual predictor and the queue of residuals still owed by the block.
    class residual_board;
        mode_t       mode_q;
        logic [16:0] alpha_q;
        logic [30:0] sigma_q;
        logic [63:0] square_sum;
        residual_t   owed[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned norms;

        function void reset_state();
            mode_q = MODE_FB;
            alpha_q = 17'(ONE_Q16);
            sigma_q = '0;
            square_sum = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [30:0] val);
            case (idx)
                REG_MODE: begin
                    mode_q = mode_t'(val[1:0]);
                end
                REG_ALPHA: begin
                    alpha_q = val[16:0];
                end
                REG_SIGMA: begin
                    sigma_q = val;
                end
                default: begin
                end
            endcase
        endfunction

        function automatic longint floor_q16(longint x);
            return x >>> 16;
        endfunction

        function automatic longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function automatic logic [63:0] root64(logic [63:0] x);
            logic [63:0] op;
            logic [63:0] res;
            logic [63:0] b;
            op = x;
            res = '0;
            b = 64'd1 << 62;
            while (b > op) b >>= 2;
            while (b != 0) begin
                if (op >= res + b) begin
                    op -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // alpha*base + (1 - alpha)*max(0,p)*max(0,q)
        function automatic longint blend(longint base, longint p, longint q);
            longint unsigned w;
            longint unsigned pp;
            longint unsigned qq;
            longint unsigned prod;
            longint t1;
            longint t2;
            w = (alpha_q > 17'(ONE_Q16)) ? 64'(ONE_Q16) : 64'(alpha_q);
            pp = (p > 0) ? p : 0;
            qq = (q > 0) ? q : 0;
            prod = (pp * qq) >> 16;
            if (prod > 64'd2147483647) prod = 64'd2147483647;
            t1 = floor_q16(longint'(w) * base);
            t2 = longint'(((64'(ONE_Q16) - w) * prod) >> 16);
            return clip32(t1 + t2);
        endfunction

        function void note_element(logic [95:0] data, logic last);
            longint y;
            longint v;
            longint vr;
            longint r;
            longint d;
            longint a;
            longint unsigned mag;
            longint unsigned sq;
            longint unsigned am;
            longint unsigned bm;
            residual_t e;
            y = longint'($signed(data[31:0]));
            v = longint'($signed(data[63:32]));
            vr = longint'($signed(data[95:64]));
            if (mode_q == MODE_FB) begin
                d = v - vr;
                a = clip32(y + floor_q16(d * longint'(sigma_q)));
                am = (a < 0) ? -a : a;
                bm = (v < 0) ? -v : v;
                r = blend(a + v - longint'(root64(am * am + bm * bm)), a, v);
            end else if (mode_q == MODE_PENALTY) begin
                r = blend((y < v) ? y : v, y, v);
            end else begin
                r = (y < v) ? y : v;
            end
            mag = (r < 0) ? -r : r;
            sq = mag * mag;
            if (square_sum > ~64'd0 - sq) square_sum = ~64'd0;
            else square_sum += sq;
            e.residual = r[31:0];
            e.norm_valid = last;
            if (last) begin
                e.norm = 32'(root64(square_sum));
                square_sum = '0;
            end else begin
                e.norm = '0;
            end
            owed.push_back(e);
        endfunction

        function void check_result(logic [63:0] data, logic user);
            residual_t got;
            residual_t exp_r;
            got = {data[31:0], data[63:32], user};
            if (owed.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time, data, user);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            checked++;
            if (user) norms++;
            if (got.residual !== exp_r.residual) begin
                $display("%0t: residual exp %h got %h", $time, exp_r.residual, got.residual);
                errors++;
            end
            if (got.norm !== exp_r.norm) begin
                $display("%0t: norm exp %h got %h", $time, exp_r.norm, got.norm);
                errors++;
            end
            if (got.norm_valid !== exp_r.norm_valid) begin
                $display("%0t: norm_valid exp %b got %b", $time, exp_r.norm_valid,
                         got.norm_valid);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // y, v, vbar
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // residual_value, vector_norm
    logic        m_axis_tuser;   // norm_valid
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [30:0] cfg_data;

    residual_board board;
    int unsigned   idle_cycles;
    bit            hold_off;      // long receiver stall requested by the stimulus
    int unsigned   sent;

    complementarity_residual_norm_top u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check every result transaction and count quiet cycles for the watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results owed", $time, board.owed.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    initial begin
        int unsigned phase;
        int unsigned n;
        m_axis_tready = 1'b0;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(posedge aclk);
                hold_off = 1'b0;
            end
            phase++;
            // calm stretches, then stretches of light and then of heavy random stalls
            if ((phase / 300) % 3 == 0) m_axis_tready <= 1'b1;
            else if ((phase / 300) % 3 == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
        cfg_we   <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one element; hold it until the transaction completes.
    task automatic send_element(logic [31:0] y, logic [31:0] v, logic [31:0] vr, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vr, v, y};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_element({vr, v, y}, last);
        sent++;
    endtask

    task automatic pause_sender(int unsigned n);
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Drain all owed results, then let the block settle before a register write.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 131072) - 65536;     // between minus one and one
            3: return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Random vectors of 1..12 elements with bursts and gaps on the sender.
    task automatic random_vectors(int unsigned count);
        int unsigned i;
        int unsigned len;
        int unsigned burst;
        len = $urandom_range(1, 12);
        burst = $urandom_range(1, 20);
        for (i = 0; i < count; i++) begin
            len--;
            send_element(pick_value(), pick_value(), pick_value(), (len == 0) || (i == count - 1));
            if (len == 0) len = $urandom_range(1, 12);
            if (--burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) == 0) pause_sender(0);
                else pause_sender($urandom_range(1, 40));
            end
        end
    endtask

    initial begin
        logic [30:0] sigmas[4];
        logic [16:0] alphas[5];
        int unsigned k;
        board = new();
        board.reset_state();
        idle_cycles = 0;
        hold_off = 1'b0;
        sent = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_MODE;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset configuration (Fischer-Burmeister, alpha one, sigma zero).
        send_element(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_element(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_element(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b1);
        wait_drained();
        // Sigma at its top with large differences saturates a.
        write_reg(REG_SIGMA, 31'h7FFF_FFFF);
        send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_element(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_element(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        wait_drained();
        // Accumulator overflow: many full-scale residuals in one vector.
        write_reg(REG_MODE, 31'(MODE_MIN));
        for (k = 0; k < 6; k++)
            send_element(32'h8000_0000, 32'h8000_0000, 32'h0, k == 5);
        wait_drained();
        // Undefined mode acts as natural min.
        write_reg(REG_MODE, 31'(MODE_RSVD));
        send_element(32'h0003_0000, 32'hFFFE_0000, 32'h1234_5678, 1'b1);
        wait_drained();
        // Penalized mode with alpha zero and alpha above one.
        write_reg(REG_MODE, 31'(MODE_PENALTY));
        write_reg(REG_ALPHA, 31'd0);
        send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_element(32'hFFFF_0000, 32'h0002_0000, 32'h0, 1'b1);
        wait_drained();
        write_reg(REG_ALPHA, 31'h1FFFF);
        send_element(32'h0002_8000, 32'h0001_0000, 32'h0, 1'b1);
        wait_drained();

        // Random phases over a spread of settings, extremes included.
        sigmas = '{31'd0, 31'd65536, 31'h7FFF_FFFF, 31'd0};
        alphas = '{17'd0, 17'd32768, 17'd65536, 17'h1FFFF, 17'd1};
        for (k = 0; k < 12; k++) begin
            sigmas[3] = 31'($urandom_range(0, 32'h0004_0000));
            write_reg(REG_MODE, 31'(k % 4));
            write_reg(REG_ALPHA, 31'(alphas[$urandom_range(0, 4)]));
            write_reg(REG_SIGMA, (k % 4 == 0) ? sigmas[$urandom_range(0, 3)] : 31'($urandom));
            if (k == 3) hold_off = 1'b1;    // receiver backs off, block fills
            random_vectors(110);
            if (k == 7) wait_drained();     // sender waits for every result
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Sent %0d elements over all modes; %0d results checked, %0d norms.",
                 sent, board.checked, board.norms);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/crn_pkg.sv
sv/crn_sqrt.sv
sv/crn_front.sv
sv/crn_back.sv
sv/complementarity_residual_norm_top.sv
bench/tb_top.sv
